FILE: design/vhoc_pkg.sv
// ----------------------------------------------------------------------------
// vhoc_pkg
// Shared types and constants of the versioned hash occurrence counter.
// ----------------------------------------------------------------------------
package vhoc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 64;
  localparam int REF_W       = 32;
  localparam int CNT_W       = 15;
  localparam int VER_W       = 16;
  localparam int SLOT_W      = 8;
  localparam int HASH_SHIFT  = 2;
  localparam bit DEPTH_POW2  = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_PASS   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_NEW  = 2'd0,
    STAT_HIT  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_PASS = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] item_ref;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic [REF_W-1:0]  first_ref;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] first;
    logic [CNT_W-1:0] count;
    logic [VER_W-1:0] stamp;
  } entry_t;

endpackage

FILE: design/versioned_hash_occurrence_counter.sv
// ----------------------------------------------------------------------------
// versioned_hash_occurrence_counter
// Linear-probe hash table counting key occurrences, bulk-cleared by version.
// ----------------------------------------------------------------------------
//   channel   ports                   direction  handshake
//   request   start, busy, request    in         taken when start & !busy
//   result    result_valid, result    out        one-cycle strobe, no stall
//
// an insert probes one slot after another until it has its result: each probe is
// one read of the entry RAM in ST_READ and one compare in ST_CHECK
// a table depth that is not a power of two adds serial hashing in ST_HASH first
// a new pass answers in the next cycle; when the version wraps, busy stays
// high while the stamps are cleared
// after reset, busy stays high during stamp clearing
// the result strobe cannot be held off by the receiver
module versioned_hash_occurrence_counter
  import vhoc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic result_valid,
  output out_t result
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_CHECK = 5'b10000
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   probes;
  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W-1:0]   rem;
  logic [IDX_W-1:0]   rem_next;
  logic [IDX_W:0]     rem_shift;
  logic [5:0]         hbit;
  logic [KEY_W-1:0]   key_q;
  logic [REF_W-1:0]   ref_q;
  logic [VER_W-1:0]   version;
  logic [VER_W-1:0]   version_inc;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  entry_t             rd;

  logic               slot_free;
  logic               slot_match;
  logic [CNT_W-1:0]   cnt_next;
  logic               accept;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign ram_re  = (state == ST_READ);

  assign idx_inc = (idx == IDX_W'(TABLE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  assign version_inc = version + VER_W'(1);

  // one step of the serial remainder, keeps rem below the depth
  assign rem_shift = {rem, key_q[hbit]};
  assign rem_next  = (rem_shift >= (IDX_W+1)'(TABLE_DEPTH))
                   ? IDX_W'(rem_shift - (IDX_W+1)'(TABLE_DEPTH))
                   : IDX_W'(rem_shift);

  assign slot_free  = (rd.stamp != version);
  assign slot_match = (rd.key == key_q);
  assign cnt_next   = (rd.count == COUNT_MAX) ? rd.count : rd.count + CNT_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = rd;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_CHECK && (slot_free || slot_match)) begin
      ram_we = 1'b1;
      if (slot_free) begin
        ram_wdata.key   = key_q;
        ram_wdata.first = ref_q;
        ram_wdata.count = CNT_W'(1);
      end else begin
        ram_wdata.count = cnt_next;
      end
      ram_wdata.stamp = version;
    end
  end

  vhoc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      version      <= VER_W'(1);
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            key_q  <= request.key;
            ref_q  <= request.item_ref;
            probes <= '0;
            rem    <= '0;
            hbit   <= 6'(KEY_W - 1);
            if (request.cmd == CMD_PASS) begin
              result_valid <= 1'b1;
              result       <= '{status: STAT_PASS, default: '0};
              if (version_inc == '0) begin
                version <= VER_W'(1);
                state   <= ST_CLEAR;
              end else begin
                version <= version_inc;
              end
            end else if (DEPTH_POW2) begin
              idx   <= request.key[HASH_SHIFT +: IDX_W];
              state <= ST_READ;
            end else begin
              state <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          rem  <= rem_next;
          hbit <= hbit - 6'd1;
          if (hbit == 6'(HASH_SHIFT)) begin
            idx   <= rem_next;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (slot_free || slot_match) begin
            result_valid     <= 1'b1;
            result.slot      <= SLOT_W'(idx);
            result.status    <= slot_free ? STAT_NEW : STAT_HIT;
            result.count     <= slot_free ? CNT_W'(1) : cnt_next;
            result.first_ref <= slot_free ? ref_q : rd.first;
            state            <= ST_IDLE;
          end else if (probes == IDX_W'(TABLE_DEPTH - 1)) begin
            result_valid <= 1'b1;
            result       <= '{status: STAT_FULL, default: '0};
            state        <= ST_IDLE;
          end else begin
            idx    <= idx_inc;
            probes <= probes + IDX_W'(1);
            state  <= ST_READ;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_pass_answers: assert property (@(posedge clk) disable iff (rst)
    (accept && request.cmd == CMD_PASS) |=> (result_valid && result.status == STAT_PASS))
    else $error("pass request not answered in the next cycle");

  a_version_nonzero: assert property (@(posedge clk) disable iff (rst)
    version != '0)
    else $error("version reached zero");

  a_new_count_one: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STAT_NEW) |-> (result.count == CNT_W'(1)))
    else $error("new entry with count other than one");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STAT_FULL)
      |-> (result.slot == '0 && result.count == '0 && result.first_ref == '0))
    else $error("table full result carries data");

  a_result_after_check: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == STAT_NEW || result.status == STAT_HIT))
      |-> $past(state == ST_CHECK))
    else $error("insert result without a probe");
`endif

endmodule

FILE: design/vhoc_ram.sv
// ----------------------------------------------------------------------------
// vhoc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vhoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/sv/versioned_hash_occurrence_counter_test.sv
// ----------------------------------------------------------------------------
// versioned_hash_occurrence_counter_test
// Self-checking bench for the versioned hash occurrence counter. A driver
// feeds insert and new-pass requests from a queue with random gaps. A monitor
// checks every result strobe against a predictor that keeps its own copy of
// the table and version. Stimulus covers directed corner cases, a full table
// and a random mix of hits, misses and collisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module versioned_hash_occurrence_counter_test;
  import vhoc_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 600;
  localparam int POOL_SIZE     = 24;

  typedef struct {
    in_t         req;
    int unsigned gap;
    bit          drain;
  } queued_req_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  request;
  logic result_valid;
  out_t result;

  queued_req_t pending_requests[$];
  out_t        predicted_outcomes[$];

  logic [KEY_W-1:0] tbl_key   [TABLE_DEPTH];
  logic [REF_W-1:0] tbl_first [TABLE_DEPTH];
  logic [CNT_W-1:0] tbl_count [TABLE_DEPTH];
  logic [VER_W-1:0] tbl_stamp [TABLE_DEPTH];
  logic [VER_W-1:0] table_version;

  int          error_count;
  int          cycle_count;
  bit          req_taken;
  bit          have_cur;
  queued_req_t cur;
  int unsigned wait_left;

  versioned_hash_occurrence_counter i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic out_t count_occurrence(in_t req);
    out_t        res;
    int unsigned home;
    int unsigned idx;
    int unsigned n;
    bit          found;
    res   = '0;
    idx   = 0;
    found = 1'b0;
    if (req.cmd == CMD_PASS) begin
      table_version++;
      if (table_version == '0) begin
        foreach (tbl_stamp[i]) tbl_stamp[i] = '0;
        table_version = VER_W'(1);
      end
      res.status = STAT_PASS;
      return res;
    end
    home = int'((req.key >> HASH_SHIFT) % 64'(TABLE_DEPTH));
    for (n = 0; n < TABLE_DEPTH && !found; n++) begin
      idx = (home + n) % TABLE_DEPTH;
      if (tbl_stamp[idx] != table_version || tbl_key[idx] == req.key) found = 1'b1;
    end
    if (!found) begin
      res.status = STAT_FULL;
      return res;
    end
    if (tbl_stamp[idx] != table_version) begin
      tbl_key[idx]   = req.key;
      tbl_first[idx] = req.item_ref;
      tbl_count[idx] = CNT_W'(1);
      tbl_stamp[idx] = table_version;
      res.status     = STAT_NEW;
    end else begin
      if (tbl_count[idx] != COUNT_MAX) tbl_count[idx]++;
      res.status = STAT_HIT;
    end
    res.slot      = SLOT_W'(idx);
    res.count     = tbl_count[idx];
    res.first_ref = tbl_first[idx];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    error_count++;
    if (error_count <= 50)
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic queue_request(cmd_t op, logic [KEY_W-1:0] k, logic [REF_W-1:0] tag,
                               int unsigned gap, bit drain);
    queued_req_t q;
    q.req.cmd      = op;
    q.req.key      = k;
    q.req.item_ref = tag;
    q.gap          = gap;
    q.drain        = drain;
    pending_requests.push_back(q);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (start && req_taken) have_cur = 1'b0;
      if (!have_cur && pending_requests.size() != 0) begin
        cur       = pending_requests.pop_front();
        have_cur  = 1'b1;
        wait_left = cur.gap;
      end
      if (start && !req_taken) begin
        // request still waiting for the block
      end else if (have_cur && wait_left != 0) begin
        wait_left--;
        start <= 1'b0;
      end else if (have_cur && cur.drain && predicted_outcomes.size() != 0) begin
        start <= 1'b0;
      end else if (have_cur) begin
        start   <= 1'b1;
        request <= cur.req;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin : result_check
    out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (result_valid) begin
        if (predicted_outcomes.size() == 0) begin
          report_mismatch("unexpected result, status", result.status, 0);
        end else begin
          want = predicted_outcomes.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
          if (result.slot !== want.slot)
            report_mismatch("slot", result.slot, want.slot);
          if (result.count !== want.count)
            report_mismatch("count", result.count, want.count);
          if (result.first_ref !== want.first_ref)
            report_mismatch("first_ref", result.first_ref, want.first_ref);
        end
      end
      if (start && !busy) predicted_outcomes.push_back(count_occurrence(request));
    end
  end

  initial begin
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] key_pool  [POOL_SIZE];
    logic [KEY_W-1:0] full_keys [4];
    int unsigned      n;
    int unsigned      roll;
    int unsigned      gap;
    bit               no_idle;

    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    error_count = 0;
    cycle_count = 0;
    req_taken   = 1'b0;
    have_cur    = 1'b0;
    wait_left   = 0;
    no_idle     = 1'b0;
    foreach (tbl_stamp[i]) begin
      tbl_key[i]   = '0;
      tbl_first[i] = '0;
      tbl_count[i] = '0;
      tbl_stamp[i] = '0;
    end
    table_version = VER_W'(1);

    for (n = 0; n < POOL_SIZE; n++) begin
      key_pool[n] = rand_key();
      if (n < 12) key_pool[n][HASH_SHIFT +: IDX_W] = IDX_W'($urandom_range(255, 250));
    end

    // directed corner cases
    queue_request(CMD_INSERT, '0, '0, 0, 0);
    queue_request(CMD_INSERT, '0, '1, 0, 0);
    queue_request(CMD_INSERT, '1, '1, 1, 0);
    queue_request(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h1234_5678, 0, 0);
    queue_request(CMD_INSERT, 64'h1, 32'h0000_0001, 2, 0);
    queue_request(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 0, 0);
    queue_request(CMD_INSERT, 64'h3, 32'h5555_AAAA, 0, 0);
    queue_request(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 0, 0);
    queue_request(CMD_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555, 3, 0);
    queue_request(CMD_PASS, '1, '1, 0, 0);
    queue_request(CMD_INSERT, '0, 32'h0000_0002, 0, 0);
    queue_request(CMD_INSERT, '0, 32'hFFFF_0000, 0, 0);
    queue_request(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0BAD_F00D, 0, 0);
    queue_request(CMD_PASS, '0, '0, 0, 1);
    queue_request(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 0, 0);
    queue_request(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 0, 1);

    // fill every slot, then miss on a full table and hit on stored keys
    queue_request(CMD_PASS, rand_key(), $urandom, 0, 1);
    for (n = 0; n < TABLE_DEPTH; n++) begin
      k = rand_key();
      k[HASH_SHIFT +: IDX_W] = IDX_W'(n);
      if (n < 4) full_keys[n] = k;
      queue_request(CMD_INSERT, k, $urandom, pick_gap(), 0);
    end
    for (n = 0; n < 4; n++) begin
      queue_request(CMD_INSERT, rand_key(), $urandom, pick_gap(), 0);
      queue_request(CMD_INSERT, full_keys[n], $urandom, pick_gap(), 0);
    end

    // random mix
    queue_request(CMD_PASS, rand_key(), $urandom, 0, 1);
    for (n = 0; n < 200; n++) begin
      if (n % 25 == 0) no_idle = ($urandom_range(3, 0) == 0);
      gap  = no_idle ? 0 : pick_gap();
      roll = $urandom_range(99, 0);
      if (roll < 5) begin
        queue_request(CMD_PASS, rand_key(), $urandom, gap, roll == 0);
      end else begin
        if (roll < 55) begin
          k = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
        end else if (roll < 65) begin
          k = rand_key();
          k[HASH_SHIFT +: IDX_W] =
            key_pool[$urandom_range(POOL_SIZE - 1, 0)][HASH_SHIFT +: IDX_W];
        end else begin
          k = rand_key();
        end
        queue_request(CMD_INSERT, k, $urandom, gap, $urandom_range(39, 0) == 0);
      end
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || have_cur || predicted_outcomes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
design/vhoc_pkg.sv
design/vhoc_ram.sv
design/versioned_hash_occurrence_counter.sv
tb/sv/versioned_hash_occurrence_counter_test.sv
